@@ src/length_prefixed_frame_receiver_assert.svh @@
// Assertion macros for the frame receiver checks.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define LPFR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lpfr check failed");

// Next-cycle implication, clocked on clock, off during reset.
`define LPFR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lpfr check failed");

`endif

@@ src/lpfr_pkg.sv @@
`timescale 1ns / 1ps
package lpfr_pkg;

   localparam int BUF_BYTES_DEF = 512;
   localparam logic [7:0] START_MARKER_RST = 8'h02;
   localparam logic [7:0] END_MARKER_RST = 8'h03;

   localparam int FLEN_W = 10;
   localparam int OUTQ_DEPTH = 3;
   localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

   typedef enum logic [1:0] {
      REQ_BYTE    = 2'd0,
      REQ_READ    = 2'd1,
      REQ_RELEASE = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      PH_WAIT_START = 3'd0,
      PH_LENGTH     = 3'd1,
      PH_PAYLOAD    = 3'd2,
      PH_WAIT_END   = 3'd3,
      PH_BUSY       = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED = 3'd0,
      ST_COMPLETE = 3'd1,
      ST_TOO_BIG  = 3'd2,
      ST_BAD_END  = 3'd3,
      ST_DROPPED  = 3'd4,
      ST_READ     = 3'd5,
      ST_RELEASED = 3'd6,
      ST_NOTHING  = 3'd7
   } status_type;

   typedef enum logic [0:0] {
      CSR_START_MARKER = 1'b0,
      CSR_END_MARKER   = 1'b1
   } csr_reg_type;

   // control stage result, waiting for the buffer read data
   typedef struct packed {
      logic              valid;
      status_type        status;
      logic              rd_hit;
      logic [FLEN_W-1:0] frame_length;
   } stage_type;

   typedef struct packed {
      status_type        status;
      logic [7:0]        read_data;
      logic [FLEN_W-1:0] frame_length;
   } rsp_word_type;

endpackage

@@ src/lpfr_ctrl.sv @@
`timescale 1ns / 1ps
module lpfr_ctrl #(
   parameter int BUF_BYTES = lpfr_pkg::BUF_BYTES_DEF,
   parameter int ADDR_W = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          req_type,
   input  logic [7:0]          rx_byte,
   input  logic [8:0]          read_index,
   input  logic [7:0]          start_marker,
   input  logic [7:0]          end_marker,
   output logic                wr_en,
   output logic [ADDR_W-1:0]   wr_addr,
   output logic [7:0]          wr_data,
   output logic                rd_en,
   output logic [ADDR_W-1:0]   rd_addr,
   output lpfr_pkg::stage_type stage
);
   import lpfr_pkg::*;

   localparam int CNT_W = $clog2(BUF_BYTES + 1);

   req_kind_type     req;
   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_inc;
   logic [CNT_W-1:0] length_ff, length_in;
   logic [7:0]       len_lo_ff, len_lo_in;
   logic [15:0]      full_len;
   logic             too_big;
   logic             in_range;
   status_type       status;
   stage_type        stage_ff, stage_in;

   assign req      = req_kind_type'(req_type);
   assign full_len = {rx_byte, len_lo_ff};
   assign too_big  = 32'(full_len) > BUF_BYTES;
   assign cnt_inc  = cnt_ff + 1'b1;
   assign in_range = 32'(read_index) < BUF_BYTES;

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (req)
            REQ_BYTE: begin
               case (phase_ff)
                  PH_WAIT_START: begin
                     if (rx_byte == start_marker) phase_in = PH_LENGTH;
                  end
                  PH_LENGTH: begin
                     if (cnt_ff != '0) begin
                        if (too_big) phase_in = PH_WAIT_START;
                        else if (full_len == 16'd0) phase_in = PH_WAIT_END;
                        else phase_in = PH_PAYLOAD;
                     end
                  end
                  PH_PAYLOAD: begin
                     if (cnt_inc >= length_ff) phase_in = PH_WAIT_END;
                  end
                  PH_WAIT_END: begin
                     phase_in = (rx_byte == end_marker) ? PH_BUSY : PH_WAIT_START;
                  end
                  default: ;
               endcase
            end
            REQ_RELEASE: begin
               if (phase_ff == PH_BUSY) phase_in = PH_WAIT_START;
            end
            default: ;
         endcase
      end
   end

   // outputs and datapath updates
   always_comb begin
      status    = ST_ACCEPTED;
      cnt_in    = cnt_ff;
      len_lo_in = len_lo_ff;
      length_in = length_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      if (accept) begin
         case (req)
            REQ_BYTE: begin
               case (phase_ff)
                  PH_WAIT_START: begin
                     if (rx_byte == start_marker) cnt_in = '0;
                  end
                  PH_LENGTH: begin
                     if (cnt_ff == '0) begin
                        len_lo_in = rx_byte;
                        cnt_in    = CNT_W'(1);
                     end else begin
                        cnt_in = '0;
                        if (too_big) status = ST_TOO_BIG;
                        else length_in = CNT_W'(full_len);
                     end
                  end
                  PH_PAYLOAD: begin
                     wr_en  = 1'b1;
                     cnt_in = cnt_inc;
                  end
                  PH_WAIT_END: begin
                     cnt_in = '0;
                     status = (rx_byte == end_marker) ? ST_COMPLETE : ST_BAD_END;
                  end
                  default: status = ST_DROPPED;
               endcase
            end
            REQ_READ: begin
               status = ST_READ;
               rd_en  = 1'b1;
            end
            REQ_RELEASE: begin
               if (phase_ff == PH_BUSY) begin
                  cnt_in = '0;
                  status = ST_RELEASED;
               end else begin
                  status = ST_NOTHING;
               end
            end
            default: ;
         endcase
      end
   end

   // counter stays below the declared length, so the write is always in range
   assign wr_addr = cnt_ff[ADDR_W-1:0];
   assign wr_data = rx_byte;
   assign rd_addr = ADDR_W'(read_index);

   always_comb begin
      stage_in.valid        = accept;
      stage_in.status       = status;
      stage_in.rd_hit       = rd_en & in_range;
      stage_in.frame_length = (phase_in == PH_BUSY) ? FLEN_W'(length_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT_START;
         cnt_ff    <= '0;
         len_lo_ff <= '0;
         length_ff <= '0;
         stage_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         len_lo_ff <= len_lo_in;
         length_ff <= length_in;
         stage_ff  <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule

@@ src/lpfr_buf.sv @@
`timescale 1ns / 1ps
module lpfr_buf #(
   parameter int BUF_BYTES = lpfr_pkg::BUF_BYTES_DEF,
   parameter int ADDR_W = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);
   import lpfr_pkg::*;

   logic [7:0] mem [BUF_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/lpfr_outq.sv @@
`timescale 1ns / 1ps
module lpfr_outq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  lpfr_pkg::rsp_word_type        push_word,
   input  logic                          pop,
   output logic                          head_valid,
   output lpfr_pkg::rsp_word_type        head_word,
   output logic [lpfr_pkg::OUTQ_CNT_W-1:0] count
);
   import lpfr_pkg::*;

   rsp_word_type          entry_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0] head_ff, head_in;
   logic [OUTQ_PTR_W-1:0] tail_ff, tail_in;
   logic [OUTQ_CNT_W-1:0] count_ff, count_in;
   logic                  do_pop;

   assign do_pop = pop & (count_ff != '0);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[tail_ff] <= push_word;
   end

   assign head_valid = count_ff != '0;
   assign head_word  = entry_ff[head_ff];
   assign count      = count_ff;

endmodule

@@ src/length_prefixed_frame_receiver.sv @@
// Words pass the control stage register, then the output queue. Throughput:
// one word per cycle unless stalled; each word uses the buffer's single write
// port (payload byte) or its single registered read port (read request).
// A three-word output queue lets input continue while a result is stalled.
// Reset (synchronous, active high) returns to waiting for a start marker,
// empties the queue and restores markers 0x02/0x03; the buffer is not cleared.
`timescale 1ns / 1ps
module length_prefixed_frame_receiver #(
   parameter int BUF_BYTES = lpfr_pkg::BUF_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_rx_byte,
   input  logic [8:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_read_data,
   output logic [9:0]  rsp_frame_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import lpfr_pkg::*;

   localparam int ADDR_W = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;

   logic [7:0]            start_marker_ff;
   logic [7:0]            end_marker_ff;
   logic                  accept;
   logic                  wr_en, rd_en;
   logic [ADDR_W-1:0]     wr_addr, rd_addr;
   logic [7:0]            wr_data, rd_data;
   stage_type             stage;
   rsp_word_type          push_word, head_word;
   logic [OUTQ_CNT_W-1:0] q_count;
   logic                  head_valid;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RST;
         end_marker_ff   <= END_MARKER_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_reg_type'(csr_index))
            CSR_START_MARKER: start_marker_ff <= csr_wdata;
            CSR_END_MARKER:   end_marker_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // room for the word in the control stage plus one more
   assign req_stall = ({1'b0, q_count} + {{OUTQ_CNT_W{1'b0}}, stage.valid}
                       + (OUTQ_CNT_W + 1)'(1)) > (OUTQ_CNT_W + 1)'(OUTQ_DEPTH);
   assign accept    = req_valid & ~req_stall;

   lpfr_ctrl #(
      .BUF_BYTES (BUF_BYTES),
      .ADDR_W    (ADDR_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_type     (req_type),
      .rx_byte      (req_rx_byte),
      .read_index   (req_read_index),
      .start_marker (start_marker_ff),
      .end_marker   (end_marker_ff),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .stage        (stage)
   );

   lpfr_buf #(
      .BUF_BYTES (BUF_BYTES),
      .ADDR_W    (ADDR_W)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      push_word.status       = stage.status;
      push_word.read_data    = stage.rd_hit ? rd_data : 8'd0;
      push_word.frame_length = stage.frame_length;
   end

   lpfr_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (stage.valid),
      .push_word  (push_word),
      .pop        (~rsp_stall),
      .head_valid (head_valid),
      .head_word  (head_word),
      .count      (q_count)
   );

   assign rsp_valid        = head_valid;
   assign rsp_status       = head_word.status;
   assign rsp_read_data    = head_word.read_data;
   assign rsp_frame_length = head_word.frame_length;

endmodule

@@ src/lpfr_chk.sv @@
`timescale 1ns / 1ps
`include "length_prefixed_frame_receiver_assert.svh"
module lpfr_chk (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_status,
   input logic [7:0] rsp_read_data,
   input logic [9:0] rsp_frame_length
);
   import lpfr_pkg::*;

   // data only ever rides on a read result
   `LPFR_ASSERT_NOW(a_data_only_on_read, rsp_valid && (rsp_status != ST_READ), rsp_read_data == 8'd0)

   // no frame is held after a release or a rejected frame
   `LPFR_ASSERT_NOW(a_no_length_when_free, rsp_valid && (rsp_status == ST_RELEASED || rsp_status == ST_TOO_BIG || rsp_status == ST_BAD_END), rsp_frame_length == 10'd0)

   `LPFR_ASSERT_NEXT(a_stalled_word_holds, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_read_data) && $stable(rsp_frame_length))

   // queue comes out of reset empty
   `LPFR_ASSERT_NOW(a_empty_after_reset, $fell(reset), !rsp_valid)

endmodule

bind length_prefixed_frame_receiver lpfr_chk u_lpfr_chk (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_read_data    (rsp_read_data),
   .rsp_frame_length (rsp_frame_length)
);

@@ sim/length_prefixed_frame_receiver_tb.sv @@
`timescale 1ns / 1ps
module length_prefixed_frame_receiver_tb;
   import lpfr_pkg::*;

   localparam int STORE_BYTES = BUF_BYTES_DEF;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES = 60;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_type;
   logic [7:0] req_rx_byte;
   logic [8:0] req_read_index;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [2:0] rsp_status;
   logic [7:0] rsp_read_data;
   logic [9:0] rsp_frame_length;
   logic       csr_valid;
   logic       csr_ready;
   logic [0:0] csr_index;
   logic [7:0] csr_wdata;

   length_prefixed_frame_receiver i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_rx_byte      (req_rx_byte),
      .req_read_index   (req_read_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_read_data    (rsp_read_data),
      .rsp_frame_length (rsp_frame_length),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // frame parser shadow state
   phase_type   rx_phase;
   logic [15:0] rx_len;
   logic [9:0]  rx_count;
   logic [7:0]  mark_open;
   logic [7:0]  mark_close;
   logic [7:0]  frame_store [STORE_BYTES];
   bit          frame_store_ok [STORE_BYTES];
   int          stored_cnt;

   rsp_word_type rsp_pending [$];
   int errors;
   int words_sent;
   int send_idle_pct;
   int recv_idle_pct;
   bit hold_req;
   int hold_left;
   int idle_cycles;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] b;
      logic [8:0] idx;
      bit         typed;
      status_type st;
      logic [7:0] data;
      logic [9:0] flen;
   } dir_row_type;

   dir_row_type dir_tab [27] = '{
      '{REQ_RELEASE, 8'h00, 9'h000, 1'b1, ST_NOTHING,  8'h00, 10'd0},
      '{REQ_UNUSED,  8'hFF, 9'h1FF, 1'b1, ST_ACCEPTED, 8'h00, 10'd0},
      '{REQ_BYTE,    8'hFF, 9'h000, 1'b1, ST_ACCEPTED, 8'h00, 10'd0},
      '{REQ_BYTE,    8'h00, 9'h000, 1'b1, ST_ACCEPTED, 8'h00, 10'd0},
      // length 0x0201 is one past the buffer
      '{REQ_BYTE,    8'h02, 9'h000, 1'b0, ST_ACCEPTED, 8'h00, 10'd0},
      '{REQ_BYTE,    8'h01, 9'h000, 1'b0, ST_ACCEPTED, 8'h00, 10'd0},
      '{REQ_BYTE,    8'h02, 9'h000, 1'b1, ST_TOO_BIG,  8'h00, 10'd0},
      // zero length frame
      '{REQ_BYTE,    8'h02, 9'h000, 1'b0, ST_ACCEPTED, 8'h00, 10'd0},
      '{REQ_BYTE,    8'h00, 9'h000, 1'b0, ST_ACCEPTED, 8'h00, 10'd0},
      '{REQ_BYTE,    8'h00, 9'h000, 1'b0, ST_ACCEPTED, 8'h00, 10'd0},
      '{REQ_BYTE,    8'h03, 9'h000, 1'b1, ST_COMPLETE, 8'h00, 10'd0},
      '{REQ_BYTE,    8'hAA, 9'h000, 1'b1, ST_DROPPED,  8'h00, 10'd0},
      '{REQ_RELEASE, 8'h00, 9'h000, 1'b1, ST_RELEASED, 8'h00, 10'd0},
      // two byte frame closed by a wrong end byte
      '{REQ_BYTE,    8'h02, 9'h000, 1'b0, ST_ACCEPTED, 8'h00, 10'd0},
      '{REQ_BYTE,    8'h02, 9'h000, 1'b0, ST_ACCEPTED, 8'h00, 10'd0},
      '{REQ_BYTE,    8'h00, 9'h000, 1'b0, ST_ACCEPTED, 8'h00, 10'd0},
      '{REQ_BYTE,    8'hFF, 9'h000, 1'b0, ST_ACCEPTED, 8'h00, 10'd0},
      '{REQ_BYTE,    8'h00, 9'h000, 1'b0, ST_ACCEPTED, 8'h00, 10'd0},
      '{REQ_BYTE,    8'h04, 9'h000, 1'b1, ST_BAD_END,  8'h00, 10'd0},
      '{REQ_BYTE,    8'h02, 9'h000, 1'b0, ST_ACCEPTED, 8'h00, 10'd0},
      '{REQ_BYTE,    8'h01, 9'h000, 1'b0, ST_ACCEPTED, 8'h00, 10'd0},
      '{REQ_BYTE,    8'h00, 9'h000, 1'b0, ST_ACCEPTED, 8'h00, 10'd0},
      '{REQ_BYTE,    8'h5A, 9'h000, 1'b0, ST_ACCEPTED, 8'h00, 10'd0},
      '{REQ_BYTE,    8'h03, 9'h000, 1'b1, ST_COMPLETE, 8'h00, 10'd1},
      '{REQ_READ,    8'h00, 9'h000, 1'b1, ST_READ,     8'h5A, 10'd1},
      // index 1 still holds the byte of the rejected frame
      '{REQ_READ,    8'h00, 9'h001, 1'b1, ST_READ,     8'h00, 10'd1},
      '{REQ_RELEASE, 8'h00, 9'h000, 1'b1, ST_RELEASED, 8'h00, 10'd0}
   };

   function automatic rsp_word_type frame_rx_step(input logic [1:0] kind, input logic [7:0] b,
                                                  input logic [8:0] idx);
      rsp_word_type r;
      r = '0;
      r.status = ST_ACCEPTED;
      case (kind)
         REQ_BYTE: begin
            case (rx_phase)
               PH_WAIT_START: begin
                  if (b == mark_open) begin
                     rx_phase = PH_LENGTH;
                     rx_count = '0;
                  end
               end
               PH_LENGTH: begin
                  if (rx_count == 0) begin
                     rx_len[7:0] = b;
                     rx_count = 10'd1;
                  end else begin
                     rx_len[15:8] = b;
                     rx_count = '0;
                     if (rx_len > STORE_BYTES) begin
                        rx_phase = PH_WAIT_START;
                        r.status = ST_TOO_BIG;
                     end else if (rx_len == 0) begin
                        rx_phase = PH_WAIT_END;
                     end else begin
                        rx_phase = PH_PAYLOAD;
                     end
                  end
               end
               PH_PAYLOAD: begin
                  if (rx_count < STORE_BYTES) begin
                     frame_store[rx_count[8:0]] = b;
                     if (!frame_store_ok[rx_count[8:0]]) stored_cnt++;
                     frame_store_ok[rx_count[8:0]] = 1'b1;
                  end
                  rx_count = rx_count + 10'd1;
                  if (rx_count >= rx_len) rx_phase = PH_WAIT_END;
               end
               PH_WAIT_END: begin
                  rx_count = '0;
                  if (b == mark_close) begin
                     rx_phase = PH_BUSY;
                     r.status = ST_COMPLETE;
                  end else begin
                     rx_phase = PH_WAIT_START;
                     r.status = ST_BAD_END;
                  end
               end
               default: r.status = ST_DROPPED;
            endcase
         end
         REQ_READ: begin
            r.status = ST_READ;
            r.read_data = frame_store[idx];
         end
         REQ_RELEASE: begin
            if (rx_phase == PH_BUSY) begin
               rx_phase = PH_WAIT_START;
               rx_count = '0;
               r.status = ST_RELEASED;
            end else begin
               r.status = ST_NOTHING;
            end
         end
         default: ;
      endcase
      r.frame_length = (rx_phase == PH_BUSY) ? rx_len[9:0] : '0;
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic offer_word(input logic [1:0] kind, input logic [7:0] b, input logic [8:0] idx,
                             input bit typed = 1'b0, input rsp_word_type want = '0);
      rsp_word_type pred;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_rx_byte <= b;
      req_read_index <= idx;
      do @(posedge clock); while (req_stall);
      words_sent++;
      pred = frame_rx_step(kind, b, idx);
      rsp_pending.push_back(typed ? want : pred);
   endtask

   task automatic offer_byte(input logic [7:0] b);
      offer_word(REQ_BYTE, b, 9'($urandom_range(511)));
   endtask

   // only entries already written may be read back
   task automatic offer_read();
      logic [8:0] idx;
      if (stored_cnt == 0) begin
         offer_word(REQ_UNUSED, 8'($urandom_range(255)), 9'($urandom_range(511)));
      end else begin
         do idx = 9'($urandom_range(511)); while (!frame_store_ok[idx]);
         offer_word(REQ_READ, 8'($urandom_range(255)), idx);
      end
   endtask

   task automatic offer_noise();
      logic [7:0] b;
      int sel;
      sel = $urandom_range(99);
      b = 8'($urandom_range(255));
      if (sel < 40) begin
         // keep noise from opening a frame
         if (rx_phase == PH_WAIT_START && b == mark_open) b = b ^ 8'h01;
         offer_byte(b);
      end else if (sel < 70) begin
         offer_read();
      end else if (sel < 85) begin
         offer_word(REQ_RELEASE, b, 9'($urandom_range(511)));
      end else begin
         offer_word(REQ_UNUSED, b, 9'($urandom_range(511)));
      end
   endtask

   // bring the parser back to waiting for a start marker
   task automatic resync();
      while (rx_phase != PH_WAIT_START) begin
         if (rx_phase == PH_BUSY) offer_word(REQ_RELEASE, 8'h00, 9'($urandom_range(511)));
         else if (rx_phase == PH_LENGTH) offer_byte(8'hFF);
         else offer_byte(8'($urandom_range(255)));
      end
   endtask

   // cut < 0 or >= len sends the whole frame, else stops after cut payload words
   task automatic send_frame(input int len, input bit good_end, input int cut);
      int n;
      resync();
      offer_byte(mark_open);
      offer_byte(len[7:0]);
      offer_byte(len[15:8]);
      if (len > STORE_BYTES) return;
      n = (cut >= 0 && cut < len) ? cut : len;
      for (int i = 0; i < n; i++) offer_byte(8'($urandom_range(255)));
      if (n < len) return;
      if (good_end) offer_byte(mark_close);
      else offer_byte(mark_close ^ 8'($urandom_range(1, 255)));
   endtask

   task automatic busy_traffic();
      int k;
      k = $urandom_range(3);
      for (int i = 0; i < k; i++) offer_noise();
      offer_word(REQ_RELEASE, 8'($urandom_range(255)), 9'($urandom_range(511)));
      if ($urandom_range(1)) offer_read();
      if ($urandom_range(4) == 0) offer_word(REQ_RELEASE, 8'h00, 9'($urandom_range(511)));
   endtask

   function automatic int pick_len();
      int r;
      r = $urandom_range(99);
      if (r < 8) return 0;
      if (r < 75) return $urandom_range(1, 16);
      if (r < 95) return $urandom_range(17, 64);
      return $urandom_range(65, 200);
   endfunction

   function automatic int pick_big();
      int r;
      r = $urandom_range(2);
      if (r == 0) return STORE_BYTES + 1;
      if (r == 1) return 65535;
      return $urandom_range(STORE_BYTES + 1, 65535);
   endfunction

   task automatic random_scenario();
      int sel;
      int len;
      sel = $urandom_range(99);
      len = pick_len();
      if (sel < 55) begin
         send_frame(len, 1'b1, -1);
         busy_traffic();
      end else if (sel < 67) begin
         send_frame(len, 1'b0, -1);
      end else if (sel < 75) begin
         send_frame(pick_big(), 1'b1, -1);
      end else if (sel < 83) begin
         send_frame(len, 1'b1, $urandom_range(len));
      end else begin
         repeat ($urandom_range(1, 6)) offer_noise();
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (rsp_pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_START_MARKER) mark_open = val;
      else mark_close = val;
   endtask

   // receiver side: random stall, plus one long hold on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_pending.size() == 0) begin
            $error("response word with nothing pending");
            errors++;
         end else begin
            want = rsp_pending.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_read_data !== want.read_data) begin
               $error("read_data: expected %0d, got %0d", want.read_data, rsp_read_data);
               errors++;
            end
            if (rsp_frame_length !== want.frame_length) begin
               $error("frame_length: expected %0d, got %0d",
                      want.frame_length, rsp_frame_length);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      rsp_word_type want;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_BYTE;
      req_rx_byte = '0;
      req_read_index = '0;
      csr_valid = 1'b0;
      csr_index = CSR_START_MARKER;
      csr_wdata = '0;
      errors = 0;
      words_sent = 0;
      hold_req = 1'b0;
      hold_left = 0;
      idle_cycles = 0;
      send_idle_pct = 37;
      recv_idle_pct = 81;
      rx_phase = PH_WAIT_START;
      rx_len = '0;
      rx_count = '0;
      mark_open = START_MARKER_RST;
      mark_close = END_MARKER_RST;
      stored_cnt = 0;
      for (int i = 0; i < STORE_BYTES; i++) begin
         frame_store[i] = '0;
         frame_store_ok[i] = 1'b0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_tab[i]) begin
         want.status = dir_tab[i].st;
         want.read_data = dir_tab[i].data;
         want.frame_length = dir_tab[i].flen;
         offer_word(dir_tab[i].kind, dir_tab[i].b, dir_tab[i].idx, dir_tab[i].typed, want);
      end
      drain_results();

      write_reg(CSR_START_MARKER, 8'h00);
      write_reg(CSR_END_MARKER, 8'hFF);
      while (words_sent < 270) random_scenario();
      drain_results();

      send_idle_pct = 81;
      recv_idle_pct = 37;
      write_reg(CSR_START_MARKER, 8'hFF);
      write_reg(CSR_END_MARKER, 8'h00);
      while (words_sent < 520) random_scenario();
      drain_results();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(CSR_START_MARKER, 8'($urandom_range(255)));
      write_reg(CSR_END_MARKER, 8'($urandom_range(255)));
      // full-size frame while the response side is held off
      hold_req = 1'b1;
      send_frame(STORE_BYTES, 1'b1, -1);
      offer_word(REQ_READ, 8'h00, 9'h1FF);
      busy_traffic();
      while (words_sent < 1050) random_scenario();
      drain_results();

      repeat (8) @(posedge clock);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
